// File: src/rbc_pkg.sv
// Shared types, constants and digit mapping functions for the radix base converter.
`timescale 1ns / 1ps

package rbc_pkg;

	localparam int ACC_W   = 64;
	localparam int STEP_W  = $clog2(ACC_W);
	localparam int DIGIT_W = 6;
	localparam int BASE_W  = 6;
	localparam int CHAR_W  = 7;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ACC_W - 1);

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

	localparam logic REG_IN_BASE  = 1'b0;
	localparam logic REG_OUT_BASE = 1'b1;

	localparam logic [BASE_W-1:0] IN_BASE_RESET  = 6'd10;
	localparam logic [BASE_W-1:0] OUT_BASE_RESET = 6'd10;

	localparam logic signed [7:0] MAP_ZERO      = 8'sd48;
	localparam logic signed [7:0] MAP_GAP_LIMIT = 8'sd16;
	localparam logic signed [7:0] MAP_GAP       = 8'sd7;
	localparam logic signed [7:0] MAP_LOW_LIMIT = 8'sd40;
	localparam logic signed [7:0] MAP_LOW       = 8'sd32;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
	localparam logic [CHAR_W-1:0] DIGIT_TEN = 7'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  dividend;
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [ACC_W-1:0]   quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

	function automatic logic signed [7:0] map_digit(input logic [CHAR_W-1:0] c);
		logic signed [7:0] d;
		d = $signed({1'b0, c}) - MAP_ZERO;
		if (d > MAP_GAP_LIMIT) begin
			d = d - MAP_GAP;
			if (d > MAP_LOW_LIMIT) begin
				d = d - MAP_LOW;
			end
		end
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] v);
		logic [CHAR_W-1:0] r;
		if ({1'b0, v} > DIGIT_TEN - 7'd1) begin
			r = CHAR_A - DIGIT_TEN + {1'b0, v};
		end else begin
			r = CHAR_ZERO + {1'b0, v};
		end
		return r;
	endfunction

endpackage

// File: src/rbc_divider.sv
// Restoring divider that divides a 64-bit word by a small base, one quotient bit per cycle.
`timescale 1ns / 1ps

module rbc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  rbc_pkg::div_req_t req,
	output rbc_pkg::div_rsp_t rsp
);

	logic                          run_q;
	logic                          done_q;
	logic [rbc_pkg::STEP_W-1:0]    cnt_q;
	logic [rbc_pkg::ACC_W-1:0]     num_q;
	logic [rbc_pkg::DIGIT_W-1:0]   rem_q;
	logic [rbc_pkg::BASE_W-1:0]    div_q;
	logic [rbc_pkg::DIGIT_W:0]     trial;
	logic                          fits;
	logic [rbc_pkg::DIGIT_W:0]     rem_next;

	always_comb begin
		trial    = {rem_q, num_q[rbc_pkg::ACC_W-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? trial - {1'b0, div_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + rbc_pkg::STEP_W'(1);
			if (cnt_q == rbc_pkg::STEP_LAST) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			num_q <= {num_q[rbc_pkg::ACC_W-2:0], fits};
			rem_q <= rem_next[rbc_pkg::DIGIT_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = num_q;
	assign rsp.remainder = rem_q;

endmodule

// File: src/rbc_stack.sv
// Remainder stack memory with one write port and one registered read port.
`timescale 1ns / 1ps

module rbc_stack #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [rbc_pkg::DIGIT_W-1:0]  wdata,
	input  logic                         re,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [rbc_pkg::DIGIT_W-1:0]  rdata
);

	logic [rbc_pkg::DIGIT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/radix_base_converter.sv
// Top level of the radix base converter: register port, accumulator and conversion sequencer.
//
// Channel   Direction  Handshake                 Word
// input     in         start, busy               digit_char, last_char
// output    out        strobe                    out_char, last_digit
// config    in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A character that is not the last is accumulated while busy is low, and busy stays low.
// On the last character each output digit costs one division in the shared divider,
// then the stack is read out at one digit per cycle.
// Reset clears the accumulator, the sequencer and the base registers to ten.
// The receiver cannot stall, so every strobe carries a fresh word.
`timescale 1ns / 1ps

module radix_base_converter #(
	parameter int MAX_OUT_DIGITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rbc_pkg::CHAR_W-1:0]  digit_char,
	input  logic                        last_char,
	output logic                        strobe,
	output logic [rbc_pkg::CHAR_W-1:0]  out_char,
	output logic                        last_digit,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int IDX_W = $clog2(MAX_OUT_DIGITS);
	localparam int CNT_W = $clog2(MAX_OUT_DIGITS + 1);
	localparam int PROD_W = rbc_pkg::ACC_W + rbc_pkg::BASE_W;

	rbc_pkg::state_t state_q, state_d;

	logic [rbc_pkg::ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]            count_q;
	logic [rbc_pkg::BASE_W-1:0]  in_base_q;
	logic [rbc_pkg::BASE_W-1:0]  out_base_q;
	logic                        strobe_q;
	logic [rbc_pkg::CHAR_W-1:0]  out_char_q;
	logic                        last_digit_q;

	logic                        accept;
	logic                        cfg_write;
	logic signed [7:0]           digit;
	logic [PROD_W-1:0]           prod;
	logic [rbc_pkg::ACC_W-1:0]   acc_next;
	logic [rbc_pkg::BASE_W-1:0]  base_clamped;
	logic [CNT_W-1:0]            count_inc;
	logic [CNT_W-1:0]            count_dec;
	logic                        more;

	rbc_pkg::div_req_t           div_req;
	rbc_pkg::div_rsp_t           div_rsp;

	logic                        st_we;
	logic                        st_re;
	logic [rbc_pkg::DIGIT_W-1:0] st_rdata;

	assign busy      = state_q != rbc_pkg::ST_IDLE;
	assign accept    = start && !busy;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		digit    = rbc_pkg::map_digit(digit_char);
		prod     = PROD_W'(acc_q) * PROD_W'(in_base_q);
		acc_next = prod[rbc_pkg::ACC_W-1:0] + {{(rbc_pkg::ACC_W-8){digit[7]}}, digit};
	end

	always_comb begin
		if (out_base_q < rbc_pkg::BASE_MIN) begin
			base_clamped = rbc_pkg::BASE_MIN;
		end else if (out_base_q > rbc_pkg::BASE_MAX) begin
			base_clamped = rbc_pkg::BASE_MAX;
		end else begin
			base_clamped = out_base_q;
		end
	end

	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);
	assign more = (div_rsp.quotient != '0) && (count_inc < CNT_W'(MAX_OUT_DIGITS));

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = acc_next;
		div_req.divisor  = base_clamped;
		st_we            = 1'b0;
		st_re            = 1'b0;
		case (state_q)
			rbc_pkg::ST_IDLE: begin
				if (accept && last_char) begin
					div_req.start = 1'b1;
					state_d       = rbc_pkg::ST_DIV;
				end
			end
			rbc_pkg::ST_DIV: begin
				div_req.dividend = div_rsp.quotient;
				if (div_rsp.done) begin
					st_we = 1'b1;
					if (more) begin
						div_req.start = 1'b1;
					end else begin
						state_d = rbc_pkg::ST_READ;
					end
				end
			end
			rbc_pkg::ST_READ: begin
				st_re   = 1'b1;
				state_d = rbc_pkg::ST_EMIT;
			end
			rbc_pkg::ST_EMIT: begin
				if (count_q == '0) begin
					state_d = rbc_pkg::ST_IDLE;
				end else begin
					st_re = 1'b1;
				end
			end
			default: begin
				state_d = rbc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rbc_pkg::ST_IDLE;
			acc_q        <= '0;
			count_q      <= '0;
			in_base_q    <= rbc_pkg::IN_BASE_RESET;
			out_base_q   <= rbc_pkg::OUT_BASE_RESET;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= state_q == rbc_pkg::ST_EMIT;
			if (accept) begin
				acc_q <= last_char ? '0 : acc_next;
			end
			if (st_we) begin
				count_q <= count_inc;
			end else if (st_re) begin
				count_q <= count_dec;
			end
			if (cfg_write) begin
				if (paddr[2] == rbc_pkg::REG_IN_BASE) begin
					in_base_q <= pwdata[rbc_pkg::BASE_W-1:0];
				end else begin
					out_base_q <= pwdata[rbc_pkg::BASE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rbc_pkg::ST_EMIT) begin
			out_char_q   <= rbc_pkg::to_ascii(st_rdata);
			last_digit_q <= count_q == '0;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rbc_pkg::REG_OUT_BASE) begin
			prdata[rbc_pkg::BASE_W-1:0] = out_base_q;
		end else begin
			prdata[rbc_pkg::BASE_W-1:0] = in_base_q;
		end
	end

	assign strobe     = strobe_q;
	assign out_char   = out_char_q;
	assign last_digit = last_digit_q;

	rbc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rbc_stack #(
		.DEPTH (MAX_OUT_DIGITS)
	) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (div_rsp.remainder),
		.re    (st_re),
		.raddr (count_dec[IDX_W-1:0]),
		.rdata (st_rdata)
	);

endmodule
